[rtl/core/counter_priority_task_scheduler_assert.svh]
// assertion macros used by the scheduler port checker
`ifndef COUNTER_PRIORITY_TASK_SCHEDULER_ASSERT_SVH
`define COUNTER_PRIORITY_TASK_SCHEDULER_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define CPTS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scheduler check failed");

// next-cycle implication, sampled on clk, quiet during reset
`define CPTS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scheduler check failed");

`endif

[rtl/core/cpts_pkg.sv]
// ----------------------------------------------------------------------------
// cpts_pkg
// Types and constants shared by the task scheduler cells and control.
// ----------------------------------------------------------------------------
package cpts_pkg;

	// operation codes of a transaction
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_SCHED = 2'd2;

	// run states
	localparam logic [1:0] RS_RUNNING = 2'd0;
	localparam logic [1:0] RS_INTR    = 2'd1;

	// signal masks
	localparam logic [31:0] SIG_ALRM_BIT = 32'h0000_2000;
	localparam logic [31:0] UNBLOCKABLE  = 32'h0004_0100;

	// slot index width on the scan chain (largest table is 256 slots)
	localparam int IDX_W = 8;

	// reset contents of the idle task slot
	localparam logic [7:0] IDLE_COUNT = 8'd15;
	localparam logic [5:0] IDLE_PRIO  = 6'd15;

	// token handed from cell to cell during a pick
	typedef struct packed {
		logic             vld;
		logic             have;
		logic [7:0]       best;
		logic [IDX_W-1:0] idx;
	} scan_t;

	// slot write data
	typedef struct packed {
		logic        present;
		logic [1:0]  run_state;
		logic [5:0]  prio;
		logic [7:0]  cnt;
		logic [31:0] pend;
		logic [31:0] blk;
		logic [31:0] alarm;
	} slot_wr_t;

	// strobes broadcast to every cell
	typedef struct packed {
		logic       wake;
		logic       rech;
		logic [7:0] tick_cnt;
	} cell_ctl_t;

endpackage

[rtl/core/cpts_cell.sv]
// ----------------------------------------------------------------------------
// cpts_cell
// One task slot: holds its state, applies wake-up and recharge, and takes
// part in the pick by comparing against the token from its upper neighbour.
// ----------------------------------------------------------------------------
module cpts_cell import cpts_pkg::*; #(
	parameter int IDX = 1
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  logic      wr_sel,
	input  logic      tick_sel,
	input  slot_wr_t  wr,
	input  logic [31:0] now,
	input  scan_t     scan_in,
	output scan_t     scan_out,
	output logic [7:0] cnt
);

	logic        present_q;
	logic [1:0]  rs_q;
	logic [7:0]  cnt_q;
	logic [5:0]  prio_q;
	logic [31:0] alarm_q;
	logic [31:0] pend_q;
	logic [31:0] blk_q;
	scan_t       scan_q;

	logic        active;
	logic        expired;
	logic [31:0] pend_w;
	logic        deliver;
	logic [8:0]  rech_sum;
	logic [7:0]  rech_v;
	logic        pick;

	// wake-up, recharge and pick decisions
	always_comb begin
		active   = present_q && (IDX != 0);
		expired  = (alarm_q != 32'd0) && (alarm_q < now);
		pend_w   = expired ? (pend_q | SIG_ALRM_BIT) : pend_q;
		deliver  = |(pend_w & ~(blk_q & ~UNBLOCKABLE));
		rech_sum = {1'b0, 1'b0, cnt_q[7:1]} + {3'b000, prio_q};
		rech_v   = rech_sum[8] ? 8'hFF : rech_sum[7:0];
		pick     = active && (rs_q == RS_RUNNING) &&
			(!scan_in.have || (cnt_q > scan_in.best));
	end

	// slot state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= (IDX == 0);
			rs_q      <= RS_RUNNING;
			cnt_q     <= (IDX == 0) ? IDLE_COUNT : 8'd0;
			prio_q    <= (IDX == 0) ? IDLE_PRIO : 6'd1;
			alarm_q   <= '0;
			pend_q    <= '0;
			blk_q     <= '0;
		end else if (wr_sel) begin
			present_q <= wr.present;
			rs_q      <= wr.run_state;
			cnt_q     <= wr.cnt;
			prio_q    <= (wr.prio == 6'd0) ? 6'd1 : wr.prio;
			alarm_q   <= wr.alarm;
			pend_q    <= wr.pend;
			blk_q     <= wr.blk;
		end else if (tick_sel) begin
			cnt_q <= ctl.tick_cnt;
		end else if (ctl.wake && active) begin
			pend_q <= pend_w;
			if (expired) begin
				alarm_q <= '0;
			end
			if (deliver && (rs_q == RS_INTR)) begin
				rs_q <= RS_RUNNING;
			end
		end else if (ctl.rech && active) begin
			cnt_q <= rech_v;
		end
	end

	// scan token stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else begin
			scan_q.vld <= scan_in.vld;
			if (pick) begin
				scan_q.have <= 1'b1;
				scan_q.best <= cnt_q;
				scan_q.idx  <= IDX_W'(IDX);
			end else begin
				scan_q.have <= scan_in.have;
				scan_q.best <= scan_in.best;
				scan_q.idx  <= scan_in.idx;
			end
		end
	end

	assign scan_out = scan_q;
	assign cnt      = cnt_q;

endmodule

[rtl/core/counter_priority_task_scheduler.sv]
// Write, op 3 and a tick that does not reschedule go from start through ST_RESP
// to done; a schedule pass goes through ST_WAKE and ST_SCAN, and also through
// ST_RECH and a second ST_SCAN when the counters are recharged. One transaction
// at a time; the next is accepted in the cycle that done is high. The pick walks
// a token down the row of slot cells, one cell per cycle.
// Reset: asynchronous, active low; slot 0 present with counter and priority 15.
// ----------------------------------------------------------------------------
// counter_priority_task_scheduler
// Counter based task scheduler built from a row of task slot cells.
// ----------------------------------------------------------------------------
module counter_priority_task_scheduler import cpts_pkg::*; #(
	parameter int NUM_TASKS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [5:0]  slot,
	input  logic        present,
	input  logic [1:0]  run_state,
	input  logic [5:0]  priority_req,
	input  logic [7:0]  slice_count,
	input  logic [31:0] pending_signals,
	input  logic [31:0] blocked_signals,
	input  logic [31:0] alarm_time,
	input  logic [31:0] now,
	input  logic        user_mode,
	output logic        done,
	output logic [5:0]  next_task,
	output logic        did_schedule,
	output logic [7:0]  running_count
);

	localparam int IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WAKE,
		ST_SCAN,
		ST_RECH,
		ST_RESP
	} state_t;

	state_t      state_q;
	logic [IW-1:0] cur_q;
	logic [31:0] now_q;
	logic        did_q;
	logic        done_q;
	logic        inj_q;
	logic        second_q;
	logic [5:0]  next_task_q;
	logic [7:0]  run_cnt_q;

	logic        acc;
	logic [7:0]  cur_cnt;
	cell_ctl_t   ctl;
	slot_wr_t    wr;
	scan_t       inj;
	scan_t       chain [NUM_TASKS];
	logic [7:0]  cnt_all [NUM_TASKS];

	assign busy = (state_q != ST_IDLE);
	assign acc  = start && !busy;

	// counter of the current task and tick update
	always_comb begin
		cur_cnt      = cnt_all[cur_q];
		ctl.wake     = (state_q == ST_WAKE);
		ctl.rech     = (state_q == ST_RECH);
		ctl.tick_cnt = (cur_cnt > 8'd1) ? (cur_cnt - 8'd1) : 8'd0;
		wr.present   = present;
		wr.run_state = run_state;
		wr.prio      = priority_req;
		wr.cnt       = slice_count;
		wr.pend      = pending_signals;
		wr.blk       = blocked_signals;
		wr.alarm     = alarm_time;
		inj.vld      = inj_q;
		inj.have     = 1'b0;
		inj.best     = 8'd0;
		inj.idx      = '0;
	end

	// row of slot cells, token enters at the top slot
	for (genvar i = 0; i < NUM_TASKS; i++) begin : g_cell
		logic wr_sel;
		logic tick_sel;
		scan_t scan_in;

		assign wr_sel   = acc && (op == OP_WRITE) && ({3'b000, slot} == 9'(i));
		assign tick_sel = acc && (op == OP_TICK) && (cur_q == IW'(i));
		assign scan_in  = (i == NUM_TASKS - 1) ? inj : chain[(i + 1) % NUM_TASKS];

		cpts_cell #(
			.IDX(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.wr_sel   (wr_sel),
			.tick_sel (tick_sel),
			.wr       (wr),
			.now      (now_q),
			.scan_in  (scan_in),
			.scan_out (chain[i]),
			.cnt      (cnt_all[i])
		);
	end

	// sequencer and registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_q       <= '0;
			now_q       <= '0;
			did_q       <= 1'b0;
			done_q      <= 1'b0;
			inj_q       <= 1'b0;
			second_q    <= 1'b0;
			next_task_q <= '0;
			run_cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			inj_q  <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						now_q <= now;
						unique case (op)
							OP_TICK: begin
								did_q   <= (cur_cnt <= 8'd1) && user_mode;
								state_q <= ((cur_cnt <= 8'd1) && user_mode) ? ST_WAKE : ST_RESP;
							end
							OP_SCHED: begin
								did_q   <= 1'b1;
								state_q <= ST_WAKE;
							end
							default: begin
								did_q   <= 1'b0;
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_WAKE: begin
					inj_q    <= 1'b1;
					second_q <= 1'b0;
					state_q  <= ST_SCAN;
				end
				ST_SCAN: begin
					if (chain[1].vld) begin
						if (!chain[1].have) begin
							cur_q   <= '0;
							state_q <= ST_RESP;
						end else if ((chain[1].best == 8'd0) && !second_q) begin
							state_q <= ST_RECH;
						end else begin
							cur_q   <= IW'(chain[1].idx);
							state_q <= ST_RESP;
						end
					end
				end
				ST_RECH: begin
					inj_q    <= 1'b1;
					second_q <= 1'b1;
					state_q  <= ST_SCAN;
				end
				ST_RESP: begin
					done_q      <= 1'b1;
					next_task_q <= 6'(cur_q);
					run_cnt_q   <= cur_cnt;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done          = done_q;
	assign next_task     = next_task_q;
	assign did_schedule  = did_q;
	assign running_count = run_cnt_q;

endmodule

[rtl/core/cpts_checker.sv]
// ----------------------------------------------------------------------------
// cpts_checker
// Port level checks of the scheduler transaction sequence.
// ----------------------------------------------------------------------------
`include "counter_priority_task_scheduler_assert.svh"

module cpts_checker import cpts_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic       did_schedule,
	input logic [1:0] op
);

	// an accepted transaction always occupies the block
	`CPTS_ASSERT_NEXT(a_acc_busy, start && !busy, busy)
	// the result strobe closes the transaction
	`CPTS_ASSERT_NOW(a_done_idle, done, !busy)
	// one result per transaction, one cycle wide
	`CPTS_ASSERT_NEXT(a_done_pulse, done, !done)
	// a write never runs a schedule pass
	`CPTS_ASSERT_NEXT(a_wr_quick, start && !busy && (op == OP_WRITE), busy && !did_schedule)

endmodule

bind counter_priority_task_scheduler cpts_checker u_cpts_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.did_schedule (did_schedule),
	.op           (op)
);

[tb/counter_priority_task_scheduler_checker.sv]
// ----------------------------------------------------------------------------
// counter_priority_task_scheduler_checker
// Watches accepted transactions, keeps a shadow task table and compares each
// done strobe with the predicted current slot, schedule flag and counter.
// ----------------------------------------------------------------------------
module counter_priority_task_scheduler_checker import cpts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  op,
	input  logic [5:0]  slot,
	input  logic        present,
	input  logic [1:0]  run_state,
	input  logic [5:0]  priority_req,
	input  logic [7:0]  slice_count,
	input  logic [31:0] pending_signals,
	input  logic [31:0] blocked_signals,
	input  logic [31:0] alarm_time,
	input  logic [31:0] now,
	input  logic        user_mode,
	input  logic        done,
	input  logic [5:0]  next_task,
	input  logic        did_schedule,
	input  logic [7:0]  running_count,
	output int          fail_count,
	output int          waiting
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N = 64;

	typedef struct packed {
		logic [5:0] task_id;
		logic       sched;
		logic [7:0] cnt;
	} sched_result_t;

	// shadow task table
	logic        tb_present [N];
	logic [1:0]  tb_state   [N];
	logic [7:0]  tb_count   [N];
	logic [5:0]  tb_prio    [N];
	logic [31:0] tb_alarm   [N];
	logic [31:0] tb_pend    [N];
	logic [31:0] tb_blk     [N];
	logic [5:0]  tb_current;

	sched_result_t expected_results[$];

	assign waiting = expected_results.size();

	task automatic clear_table();
		for (int i = 0; i < N; i++) begin
			tb_present[i] = 1'b0;
			tb_state[i]   = RS_RUNNING;
			tb_count[i]   = 8'd0;
			tb_prio[i]    = 6'd1;
			tb_alarm[i]   = '0;
			tb_pend[i]    = '0;
			tb_blk[i]     = '0;
		end
		tb_present[0] = 1'b1;
		tb_count[0]   = IDLE_COUNT;
		tb_prio[0]    = IDLE_PRIO;
		tb_current    = '0;
	endtask

	// highest counter among running tasks, ties to the higher slot
	function automatic int best_running(output logic [5:0] pick);
		int c;
		c = -1;
		pick = '0;
		for (int i = N - 1; i > 0; i--)
			if (tb_present[i] && tb_state[i] == RS_RUNNING && int'(tb_count[i]) > c) begin
				c = int'(tb_count[i]);
				pick = i[5:0];
			end
		return c;
	endfunction

	task automatic run_pass(logic [31:0] t_now);
		logic [5:0] pick;
		int c;
		int v;
		// alarm expiry and wake-up
		for (int i = N - 1; i > 0; i--) begin
			if (!tb_present[i])
				continue;
			if (tb_alarm[i] != 0 && tb_alarm[i] < t_now) begin
				tb_pend[i] |= SIG_ALRM_BIT;
				tb_alarm[i] = '0;
			end
			if ((tb_pend[i] & ~(tb_blk[i] & ~UNBLOCKABLE)) != 0 && tb_state[i] == RS_INTR)
				tb_state[i] = RS_RUNNING;
		end
		c = best_running(pick);
		// recharge when every runnable counter is spent
		if (c == 0) begin
			for (int i = N - 1; i > 0; i--)
				if (tb_present[i]) begin
					v = int'(tb_count[i] >> 1) + int'(tb_prio[i]);
					tb_count[i] = (v > 255) ? 8'd255 : v[7:0];
				end
			c = best_running(pick);
		end
		tb_current = pick;
	endtask

	task automatic predict_transaction();
		logic ran;
		ran = 1'b0;
		case (op)
			OP_WRITE: begin
				tb_present[slot] = present;
				tb_state[slot]   = run_state;
				tb_prio[slot]    = (priority_req == 0) ? 6'd1 : priority_req;
				tb_count[slot]   = slice_count;
				tb_pend[slot]    = pending_signals;
				tb_blk[slot]     = blocked_signals;
				tb_alarm[slot]   = alarm_time;
			end
			OP_TICK: begin
				if (tb_count[tb_current] > 1)
					tb_count[tb_current] = tb_count[tb_current] - 8'd1;
				else begin
					tb_count[tb_current] = 8'd0;
					if (user_mode) begin
						run_pass(now);
						ran = 1'b1;
					end
				end
			end
			OP_SCHED: begin
				run_pass(now);
				ran = 1'b1;
			end
			default: ;
		endcase
		expected_results.push_back('{tb_current, ran, tb_count[tb_current]});
	endtask

	initial begin
		fail_count = 0;
		clear_table();
	end

	// predict on accept, compare on done
	always @(posedge clk) begin
		sched_result_t exp_r;
		if (arst_n) begin
			if (done) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: task %0d sched %0d count %0d",
							next_task, did_schedule, running_count);
				end else begin
					exp_r = expected_results.pop_front();
					if (exp_r.task_id !== next_task || exp_r.sched !== did_schedule ||
							exp_r.cnt !== running_count) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected task %0d sched %0d count %0d, got %0d %0d %0d",
								exp_r.task_id, exp_r.sched, exp_r.cnt,
								next_task, did_schedule, running_count);
					end
				end
			end
			if (start && !busy)
				predict_transaction();
		end
	end

endmodule

[tb/counter_priority_task_scheduler_test.sv]
// ----------------------------------------------------------------------------
// counter_priority_task_scheduler_test
// Drives directed and random slot writes, ticks and schedule requests into the
// scheduler with random start gaps; the checker predicts and compares.
// ----------------------------------------------------------------------------
module counter_priority_task_scheduler_test import cpts_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG = 20000;
	localparam logic [1:0] OP_NONE = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  op = OP_WRITE;
	logic [5:0]  slot = '0;
	logic        present = 1'b0;
	logic [1:0]  run_state = '0;
	logic [5:0]  priority_req = 6'd1;
	logic [7:0]  slice_count = '0;
	logic [31:0] pending_signals = '0;
	logic [31:0] blocked_signals = '0;
	logic [31:0] alarm_time = '0;
	logic [31:0] now = '0;
	logic        user_mode = 1'b0;
	logic        done;
	logic [5:0]  next_task;
	logic        did_schedule;
	logic [7:0]  running_count;
	int          fail_count;
	int          waiting;
	int          quiet_cycles = 0;
	logic [31:0] tick_clock = 32'd1000;

	counter_priority_task_scheduler DUT (.*);

	counter_priority_task_scheduler_checker checker_i (.*);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog on cycles without a transaction
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WATCHDOG) begin
			$display("FAIL");
			$finish;
		end
	end

	// present one transaction and wait for its acceptance
	task automatic issue(logic [1:0] o, logic [5:0] s, logic p, logic [1:0] rs,
			logic [5:0] pr, logic [7:0] sc, logic [31:0] pd, logic [31:0] bk,
			logic [31:0] al, logic [31:0] t, logic um, bit gaps);
		if (gaps && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		start <= 1'b1;
		op <= o; slot <= s; present <= p; run_state <= rs; priority_req <= pr;
		slice_count <= sc; pending_signals <= pd; blocked_signals <= bk;
		alarm_time <= al; now <= t; user_mode <= um;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// random slot write, alarms near the running tick clock
	task automatic random_write(bit gaps);
		logic [31:0] al;
		case ($urandom_range(0, 3))
			0: al = '0;
			1: al = $urandom();
			default: al = tick_clock + $urandom_range(0, 40) - 20;
		endcase
		issue(OP_WRITE, $urandom_range(0, 15) == 0 ? 6'($urandom_range(0, 63))
				: 6'($urandom_range(0, 11)), $urandom_range(0, 7) != 0,
			2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
			8'($urandom_range(0, 255)),
			$urandom_range(0, 1) ? $urandom() : 32'(1 << $urandom_range(0, 31)),
			$urandom_range(0, 1) ? $urandom() : 32'(1 << $urandom_range(0, 31)),
			al, tick_clock, 1'($urandom_range(0, 1)), gaps);
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: extremes, every op, signal and alarm corner cases
		issue(OP_SCHED, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0);
		issue(OP_NONE, 63, 1, 3, 63, 255, '1, '1, '1, '1, 1, 0);
		issue(OP_WRITE, 63, 1, RS_RUNNING, 0, 0, 0, 0, 0, 0, 0, 0);
		issue(OP_WRITE, 1, 1, RS_RUNNING, 63, 255, 0, 0, 0, 0, 0, 0);
		issue(OP_SCHED, 0, 0, 0, 1, 0, 0, 0, 0, 5, 0, 0);
		issue(OP_TICK, 0, 0, 0, 1, 0, 0, 0, 0, 5, 0, 0);
		issue(OP_WRITE, 2, 1, RS_INTR, 5, 200, 32'h0000_0100, '1, 0, 0, 0, 0);
		issue(OP_WRITE, 3, 1, RS_INTR, 5, 250, 32'h0000_0001, '1, 0, 0, 0, 0);
		issue(OP_WRITE, 4, 1, RS_INTR, 5, 254, 0, '1, 32'd100, 0, 0, 0);
		issue(OP_WRITE, 5, 1, RS_INTR, 5, 254, 32'h0004_0000, '1, '1, 0, 0, 0);
		issue(OP_WRITE, 6, 1, 2'd2, 5, 255, '1, 0, 0, 0, 0, 0);
		issue(OP_WRITE, 7, 1, 2'd3, 5, 255, '1, 0, 0, 0, 0, 0);
		issue(OP_SCHED, 0, 0, 0, 1, 0, 0, 0, 0, 32'd100, 0, 0);
		issue(OP_SCHED, 0, 0, 0, 1, 0, 0, 0, 0, '1, 0, 0);
		issue(OP_WRITE, 1, 0, RS_RUNNING, 1, 1, 0, 0, 0, 0, 0, 0);
		issue(OP_TICK, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0);
		issue(OP_TICK, 0, 0, 0, 1, 0, 0, 0, 0, 0, 1, 0);
		for (int i = 1; i < 8; i++)
			issue(OP_WRITE, 6'(i), 1, RS_RUNNING, 6'd63, 0, 0, 0, 0, 0, 0, 0);
		issue(OP_SCHED, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0);

		// random: mostly ticks over a small table, occasional writes and passes
		for (int n = 0; n < 1600; n++) begin
			bit gaps;
			gaps = (n < 1400);
			tick_clock = tick_clock + $urandom_range(0, 3);
			case ($urandom_range(0, 9))
				0, 1, 2: random_write(gaps);
				3: issue(OP_SCHED, 0, 0, 0, 1, 0, 0, 0, 0, tick_clock, 0, gaps);
				4: issue(OP_NONE, 6'($urandom()), 1'($urandom()), 2'($urandom()),
					6'($urandom()), 8'($urandom()), $urandom(), $urandom(),
					$urandom(), $urandom(), 1'($urandom()), gaps);
				default: issue(OP_TICK, 0, 0, 0, 1, 0, 0, 0, 0,
					$urandom_range(0, 31) == 0 ? $urandom() : tick_clock,
					$urandom_range(0, 4) != 0, gaps);
			endcase
		end
		start <= 1'b0;

		// drain
		while (waiting != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (fail_count == 0 && waiting == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/cpts_pkg.sv
rtl/core/cpts_cell.sv
rtl/core/counter_priority_task_scheduler.sv
rtl/core/cpts_checker.sv
tb/counter_priority_task_scheduler_checker.sv
tb/counter_priority_task_scheduler_test.sv
